FILE: sv/servo_cascade_sim_step_defines.svh
// ----------------------------------------------------------------------------
// servo_cascade_sim_step_defines
// assertion macros shared by the servo step design; clk and rst are taken
// from the scope of use
// ----------------------------------------------------------------------------
`ifndef SERVO_CASCADE_SIM_STEP_DEFINES_SVH
`define SERVO_CASCADE_SIM_STEP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// types, constants and saturating helpers of the cascaded servo step
// ----------------------------------------------------------------------------
package scs_pkg;

  // signed 32-bit limits
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // dt = 0.001 s as round(2^32 / 1000) with a 32-bit shift
  localparam logic [31:0] DT_NUM = 32'd4294967;
  localparam int DT_SHIFT = 32;

  // integral limit in whole units, scaled by the fraction width
  localparam int INTEG_LIMIT_UNITS = 100;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [31:0] RST_POS_GAIN = 32'd3276800;
  localparam logic [31:0] RST_VEL_P_GAIN = 32'd655360;
  localparam logic [31:0] RST_VEL_I_GAIN = 32'd6554;
  localparam logic [30:0] RST_MAX_VELOCITY = 31'd0;
  localparam logic [30:0] RST_MAX_TORQUE = 31'd65536;
  localparam logic [31:0] RST_FRICTION_COEFF = 32'd655;
  localparam logic [31:0] RST_INV_INERTIA = 32'd65536000;
  localparam logic RST_SIM_ON = 1'b1;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POS_GAIN = 3'd0,
    REG_VEL_P_GAIN = 3'd1,
    REG_VEL_I_GAIN = 3'd2,
    REG_MAX_VELOCITY = 3'd3,
    REG_MAX_TORQUE = 3'd4,
    REG_FRICTION_COEFF = 3'd5,
    REG_INV_INERTIA = 3'd6,
    REG_SIM_ON = 3'd7
  } cfg_reg_t;

  // item modes
  typedef enum logic [2:0] {
    MODE_TICK = 3'd0,
    MODE_LOAD = 3'd1,
    MODE_PRESET = 3'd2,
    MODE_HOME = 3'd3,
    MODE_STOP = 3'd4
  } mode_t;

  // multiplier operand selection
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_VCMD,
    MUL_FRIC,
    MUL_INTEG,
    MUL_PTERM,
    MUL_ITERM,
    MUL_ACCEL,
    MUL_VEL,
    MUL_POS
  } mul_op_t;

  // destination of the post-multiply result
  typedef enum logic [3:0] {
    POST_NONE,
    POST_APPLY,
    POST_PERR,
    POST_VCMD,
    POST_FRIC_VERR,
    POST_INTEG,
    POST_PTERM,
    POST_ITERM,
    POST_TORQUE,
    POST_NET,
    POST_ACCEL,
    POST_VEL,
    POST_POS
  } post_op_t;

  typedef struct packed {
    mul_op_t mul;
    post_op_t post;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sim_on;
  } dp_status_t;

  // saturate a 33-bit sum to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? S32_MIN : S32_MAX;
    end
    return v[31:0];
  endfunction

  // saturate a wide product to 32 bits
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    if (v[65:31] == {35{1'b0}} || v[65:31] == {35{1'b1}}) begin
      return v[31:0];
    end
    return v[65] ? S32_MIN : S32_MAX;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // clamp to plus or minus an unsigned 31-bit limit
  function automatic logic signed [31:0] clamp_sym(input logic signed [32:0] v,
                                                   input logic [30:0] lim);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = {2'b00, lim};
    lo = -hi;
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end
    return v[31:0];
  endfunction

endpackage

FILE: sv/scs_item_if.sv
// ----------------------------------------------------------------------------
// scs_item_if
// input channel: one word carries a mode and a fixed-point value
// ----------------------------------------------------------------------------
interface scs_item_if;
  logic valid;
  logic ready;
  logic [2:0] mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

FILE: sv/scs_result_if.sv
// ----------------------------------------------------------------------------
// scs_result_if
// output channel: axis state and torque reported for each item
// ----------------------------------------------------------------------------
interface scs_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] actual_position;
  logic signed [31:0] actual_velocity;
  logic signed [31:0] following_error;
  logic signed [31:0] torque_command;

  modport source (output valid, output actual_position, output actual_velocity,
                  output following_error, output torque_command, input ready);
  modport sink (input valid, input actual_position, input actual_velocity,
                input following_error, input torque_command, output ready);
endinterface

FILE: sv/scs_ctrl.sv
// ----------------------------------------------------------------------------
// scs_ctrl
// sequencer of the servo step: steps the shared multiplier through the
// cascade and owns both handshakes
// ----------------------------------------------------------------------------
module scs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic [2:0]          item_mode,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  scs_pkg::dp_status_t status,
  output scs_pkg::dp_cmd_t    cmd
);
  import scs_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE = 17'b1 << 0,
    ST_C1   = 17'b1 << 1,
    ST_C2   = 17'b1 << 2,
    ST_C3   = 17'b1 << 3,
    ST_C4   = 17'b1 << 4,
    ST_C5   = 17'b1 << 5,
    ST_C6   = 17'b1 << 6,
    ST_C7   = 17'b1 << 7,
    ST_C8   = 17'b1 << 8,
    ST_C9   = 17'b1 << 9,
    ST_C10  = 17'b1 << 10,
    ST_C11  = 17'b1 << 11,
    ST_C12  = 17'b1 << 12,
    ST_C13  = 17'b1 << 13,
    ST_C14  = 17'b1 << 14,
    ST_C15  = 17'b1 << 15,
    ST_DONE = 17'b1 << 16
  } state_t;

  state_t state;
  state_t state_next;
  logic accept;
  logic out_free;

  assign item_ready = (state == ST_IDLE);
  assign accept = item_valid && item_ready;
  assign out_free = !result_valid || result_ready;

  // sequence of multiplies and updates
  always_comb begin
    state_next = state;
    cmd.mul = MUL_NONE;
    cmd.post = POST_NONE;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item_mode == MODE_TICK && status.sim_on) begin
            cmd.post = POST_PERR;
            state_next = ST_C1;
          end else begin
            cmd.post = POST_APPLY;
            state_next = ST_DONE;
          end
        end
      end
      ST_C1: begin
        cmd.mul = MUL_VCMD;
        state_next = ST_C2;
      end
      ST_C2: begin
        cmd.post = POST_VCMD;
        cmd.mul = MUL_FRIC;
        state_next = ST_C3;
      end
      ST_C3: begin
        cmd.post = POST_FRIC_VERR;
        state_next = ST_C4;
      end
      ST_C4: begin
        cmd.mul = MUL_INTEG;
        state_next = ST_C5;
      end
      ST_C5: begin
        cmd.post = POST_INTEG;
        cmd.mul = MUL_PTERM;
        state_next = ST_C6;
      end
      ST_C6: begin
        cmd.post = POST_PTERM;
        cmd.mul = MUL_ITERM;
        state_next = ST_C7;
      end
      ST_C7: begin
        cmd.post = POST_ITERM;
        state_next = ST_C8;
      end
      ST_C8: begin
        cmd.post = POST_TORQUE;
        state_next = ST_C9;
      end
      ST_C9: begin
        cmd.post = POST_NET;
        state_next = ST_C10;
      end
      ST_C10: begin
        cmd.mul = MUL_ACCEL;
        state_next = ST_C11;
      end
      ST_C11: begin
        cmd.post = POST_ACCEL;
        state_next = ST_C12;
      end
      ST_C12: begin
        cmd.mul = MUL_VEL;
        state_next = ST_C13;
      end
      ST_C13: begin
        cmd.post = POST_VEL;
        state_next = ST_C14;
      end
      ST_C14: begin
        cmd.mul = MUL_POS;
        state_next = ST_C15;
      end
      ST_C15: begin
        cmd.post = POST_POS;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/scs_datapath.sv
// ----------------------------------------------------------------------------
// scs_datapath
// configuration registers, axis state, one shared multiplier with
// round and saturate, and the output word register
// ----------------------------------------------------------------------------
module scs_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [scs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [2:0]                           mode,
  input  logic signed [31:0]                   value,
  input  scs_pkg::dp_cmd_t                     cmd,
  output scs_pkg::dp_status_t                  status,
  output logic signed [31:0]                   actual_position,
  output logic signed [31:0]                   actual_velocity,
  output logic signed [31:0]                   following_error,
  output logic signed [31:0]                   torque_command
);
  import scs_pkg::*;

  localparam logic signed [65:0] HALF_F = 66'(1) << (FRAC_BITS - 1);
  localparam logic signed [65:0] HALF_DT = 66'(1) << (DT_SHIFT - 1);
  localparam logic [30:0] INTEG_LIM = 31'(INTEG_LIMIT_UNITS << FRAC_BITS);

  // configuration
  logic [31:0] pos_gain;
  logic [31:0] vel_p_gain;
  logic [31:0] vel_i_gain;
  logic [30:0] max_velocity;
  logic [30:0] max_torque;
  logic [31:0] friction_coeff;
  logic [31:0] inv_inertia;
  logic sim_on;

  // axis state
  logic signed [31:0] position_acc;
  logic signed [31:0] velocity_acc;
  logic signed [31:0] vel_integral;
  logic signed [31:0] command_position;

  // intermediate terms of one tick
  logic signed [31:0] perr;
  logic signed [31:0] vcmd;
  logic signed [31:0] verr;
  logic signed [31:0] fric;
  logic signed [31:0] pterm;
  logic signed [31:0] iterm;
  logic signed [31:0] torque;
  logic signed [31:0] net;
  logic signed [31:0] accel;

  // multiplier
  logic signed [31:0] mul_a;
  logic [31:0] mul_b;
  logic mul_dt;
  logic signed [32:0] mul_a_ext;
  logic signed [32:0] mul_b_ext;
  logic signed [65:0] prod_next;
  logic signed [65:0] prod;
  logic prod_dt;
  logic signed [65:0] rnd_f;
  logic signed [65:0] rnd_dt;
  logic signed [31:0] mq;
  logic signed [32:0] torque_sum;
  logic signed [32:0] integ_sum;

  assign status.sim_on = sim_on;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain <= RST_POS_GAIN;
      vel_p_gain <= RST_VEL_P_GAIN;
      vel_i_gain <= RST_VEL_I_GAIN;
      max_velocity <= RST_MAX_VELOCITY;
      max_torque <= RST_MAX_TORQUE;
      friction_coeff <= RST_FRICTION_COEFF;
      inv_inertia <= RST_INV_INERTIA;
      sim_on <= RST_SIM_ON;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_GAIN:       pos_gain <= cfg_wdata;
        REG_VEL_P_GAIN:     vel_p_gain <= cfg_wdata;
        REG_VEL_I_GAIN:     vel_i_gain <= cfg_wdata;
        REG_MAX_VELOCITY:   max_velocity <= cfg_wdata[30:0];
        REG_MAX_TORQUE:     max_torque <= cfg_wdata[30:0];
        REG_FRICTION_COEFF: friction_coeff <= cfg_wdata;
        REG_INV_INERTIA:    inv_inertia <= cfg_wdata;
        REG_SIM_ON:         sim_on <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_dt = 1'b0;
    case (cmd.mul)
      MUL_VCMD: begin
        mul_a = perr;
        mul_b = pos_gain;
      end
      MUL_FRIC: begin
        mul_a = velocity_acc;
        mul_b = friction_coeff;
      end
      MUL_INTEG: begin
        mul_a = verr;
        mul_b = DT_NUM;
        mul_dt = 1'b1;
      end
      MUL_PTERM: begin
        mul_a = verr;
        mul_b = vel_p_gain;
      end
      MUL_ITERM: begin
        mul_a = vel_integral;
        mul_b = vel_i_gain;
      end
      MUL_ACCEL: begin
        mul_a = net;
        mul_b = inv_inertia;
      end
      MUL_VEL: begin
        mul_a = accel;
        mul_b = DT_NUM;
        mul_dt = 1'b1;
      end
      MUL_POS: begin
        mul_a = velocity_acc;
        mul_b = DT_NUM;
        mul_dt = 1'b1;
      end
      default: ;
    endcase
  end

  // signed by unsigned product, registered
  assign mul_a_ext = {mul_a[31], mul_a};
  assign mul_b_ext = {1'b0, mul_b};
  assign prod_next = 66'(mul_a_ext) * 66'(mul_b_ext);

  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE) begin
      prod <= prod_next;
      prod_dt <= mul_dt;
    end
  end

  // round half up, shift, saturate
  assign rnd_f = (prod + HALF_F) >>> FRAC_BITS;
  assign rnd_dt = (prod + HALF_DT) >>> DT_SHIFT;
  assign mq = sat66(prod_dt ? rnd_dt : rnd_f);

  assign torque_sum = {pterm[31], pterm} + {iterm[31], iterm};
  assign integ_sum = {vel_integral[31], vel_integral} + {mq[31], mq};

  // axis state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      position_acc <= '0;
      velocity_acc <= '0;
      vel_integral <= '0;
      command_position <= '0;
    end else begin
      case (cmd.post)
        POST_APPLY: begin
          case (mode)
            MODE_LOAD:   command_position <= value;
            MODE_PRESET: velocity_acc <= value;
            MODE_HOME: begin
              position_acc <= '0;
              command_position <= '0;
            end
            MODE_STOP:   velocity_acc <= '0;
            default: ;
          endcase
        end
        POST_INTEG: vel_integral <= clamp_sym(integ_sum, INTEG_LIM);
        POST_VEL:   velocity_acc <= sat_add(velocity_acc, mq);
        POST_POS:   position_acc <= sat_add(position_acc, mq);
        default: ;
      endcase
    end
  end

  // intermediate terms
  always_ff @(posedge clk) begin
    case (cmd.post)
      POST_APPLY: torque <= '0;
      POST_PERR:  perr <= sat_sub(command_position, position_acc);
      POST_VCMD: begin
        if (max_velocity != '0) begin
          vcmd <= clamp_sym({mq[31], mq}, max_velocity);
        end else begin
          vcmd <= mq;
        end
      end
      POST_FRIC_VERR: begin
        fric <= mq;
        verr <= sat_sub(vcmd, velocity_acc);
      end
      POST_PTERM:  pterm <= mq;
      POST_ITERM:  iterm <= mq;
      POST_TORQUE: torque <= clamp_sym(torque_sum, max_torque);
      POST_NET:    net <= sat_sub(torque, fric);
      POST_ACCEL:  accel <= mq;
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      actual_position <= position_acc;
      actual_velocity <= velocity_acc;
      following_error <= sat_sub(command_position, position_acc);
      torque_command <= torque;
    end
  end

endmodule

FILE: sv/servo_cascade_sim_step.sv
// ----------------------------------------------------------------------------
// servo_cascade_sim_step
// simulated servo axis with a cascaded position P and velocity PI loop
// ----------------------------------------------------------------------------
// A tick with simulation on steps through states C1 to C15 and DONE
// before the next item is taken: the eight dependent multiplies (position
// loop, integral, two velocity terms, friction, plant, velocity and position
// integration) run one after another through a single 33 x 33 multiplier
// with a registered product, each followed by a round and saturate step.
// Load, preset, home, stop, unused modes and ticks with simulation off go
// straight to DONE. The result word sits in an output register; a new
// item is taken while it waits. Configuration writes are taken in any
// cycle but are meant for idle periods. Values are signed fixed point
// with FRAC_BITS fraction bits.
`include "servo_cascade_sim_step_defines.svh"

module servo_cascade_sim_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [scs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  scs_item_if.sink                        item,
  scs_result_if.source                    result
);
  import scs_pkg::*;

  dp_cmd_t dp_cmd;
  dp_status_t dp_status;
  logic tick_go;

  // sequencer
  scs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_mode    (item.mode),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (dp_status),
    .cmd          (dp_cmd)
  );

  // arithmetic and state
  scs_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mode            (item.mode),
    .value           (item.value),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .actual_position (result.actual_position),
    .actual_velocity (result.actual_velocity),
    .following_error (result.following_error),
    .torque_command  (result.torque_command)
  );

  // accepted tick with simulation on
  assign tick_go = item.valid && item.ready && item.mode == MODE_TICK && dp_status.sim_on;

  // running tick starts with the position loop multiply
  `SCS_ASSERT_NEXT(a_tick_starts, tick_go, dp_cmd.mul == MUL_VCMD, "tick skipped position loop")
  // multiplier only busy while an item is in work
  `SCS_ASSERT_SAME(a_mul_busy, dp_cmd.mul != MUL_NONE, !item.ready, "multiply issued while idle")
  // a loaded word is offered in the next cycle
  `SCS_ASSERT_NEXT(a_load_valid, dp_cmd.out_load, result.valid, "loaded word not offered")

endmodule
